/* rtl/core/ang_pkg.sv */
package ang_pkg;

	// Window geometry. The window length is a power of two so the mean is a shift.
	localparam int WIN_LOG2 = 9;
	localparam int WINDOW   = 1 << WIN_LOG2;
	localparam int PTR_W    = WIN_LOG2;
	localparam int WARM_W   = WIN_LOG2 + 1;

	// Sample, square and energy widths.
	localparam int SAMPLE_W = 16;
	localparam int SQ_W     = 2 * SAMPLE_W - 1;
	localparam int ENERGY_W = SQ_W + WIN_LOG2;
	localparam int MEAN_W   = ENERGY_W - WIN_LOG2;

	// Gain and ramp arithmetic.
	localparam int GAIN_W   = 16;
	localparam int THR_W    = 30;
	localparam int CNT_W    = 20;
	localparam int QUO_W    = 15;
	localparam int DIV_CW   = $clog2(QUO_W);
	localparam logic [GAIN_W-1:0] UNITY = 16'h8000;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd4;

	// Gate phase codes as reported on the output.
	typedef enum logic [1:0] {
		PH_CLOSED  = 2'd0,
		PH_OPENING = 2'd1,
		PH_OPEN    = 2'd2,
		PH_CLOSING = 2'd3
	} gate_phase_t;

endpackage

/* rtl/core/audio_noise_gate_unit.sv */
// Channel   Direction  Handshake                  Beat contents
// input     in         in_valid / in_stall        sample_in
// output    out        out_valid / out_stall      sample_out, gate_phase
// config    in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One sample is in flight at a time; a new beat is taken once the previous one has been
// handed to the output register. A warm-up sample passes the energy, gain and finish states;
// flat gain adds the decision state, and a ramp adds the multiply and restoring divide states.
// The window lives in a 512-entry RAM read at input acceptance and rewritten in the next cycle.
// arst_n clears phase, counters and energy, presets configuration; the RAM needs no clearing.
// A stalled result waits in the output register while the next sample is already taken.
module audio_noise_gate_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [ang_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ang_pkg::SAMPLE_W-1:0]   sample_out,
	output logic [1:0]                            gate_phase,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ang_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ang_pkg::CFG_DATA_W-1:0]        cfg_data
);

	import ang_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ENG  = 7'b0000010,
		ST_DEC  = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_GAIN = 7'b0100000,
		ST_FIN  = 7'b1000000
	} seq_state_t;

	// Control and configuration state.
	seq_state_t          state_q;
	gate_phase_t         phase_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [WARM_W-1:0]   warm_q;
	logic [DIV_CW-1:0]   div_cnt_q;
	logic                out_valid_q;
	logic [THR_W-1:0]    thr_q;
	logic [GAIN_W-1:0]   floor_gain_q;
	logic [CNT_W-1:0]    attack_q;
	logic [CNT_W-1:0]    release_q;
	logic [CNT_W-1:0]    hold_q;

	// Datapath registers.
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [SQ_W-1:0]            sq_s1;
	logic [CNT_W-1:0]           ramp_cnt_q;
	logic [CNT_W-1:0]           ramp_len_q;
	logic                       ramp_up_q;
	logic [CNT_W-1:0]           rem_q;
	logic [QUO_W-1:0]           dvd_q;
	logic [GAIN_W-1:0]          gain_q;
	logic signed [2*SAMPLE_W:0] gp_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	gate_phase_t                phase_out_q;

	// Combinational helpers.
	logic                       accept;
	logic                       out_free;
	logic                       warm_done;
	logic signed [SAMPLE_W-1:0] old_sample;
	logic signed [2*SAMPLE_W-1:0] sq_full;
	logic signed [2*SAMPLE_W-1:0] old_sq_full;
	logic [MEAN_W-1:0]          mean;
	logic                       mean_gt;
	logic                       mean_lt;
	logic [GAIN_W-1:0]          fl;
	logic [GAIN_W-1:0]          span;
	logic [CNT_W-1:0]           ramp_len_d;
	logic                       ramp_full;
	logic [CNT_W+GAIN_W-1:0]    prod_d;
	logic [CNT_W:0]             trial;
	logic                       trial_ge;
	logic [QUO_W-1:0]           quo_next;
	logic signed [2*SAMPLE_W:0] gp_d;
	logic signed [2*SAMPLE_W:0] gp_adj;
	logic [THR_W-1:0]           thr_wr;
	logic                       ram_we;
	logic [SAMPLE_W-1:0]        ram_rdata;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign warm_done = warm_q[WIN_LOG2];

	// Window memory: read the oldest entry on accept, replace it in the next cycle.
	assign ram_we = (state_q == ST_ENG);

	ang_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ptr_q),
		.wdata(sample_s1),
		.re   (accept),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	// Energy terms and the windowed mean against the squared threshold.
	assign old_sample  = $signed(ram_rdata);
	assign sq_full     = (2*SAMPLE_W)'(sample_in) * (2*SAMPLE_W)'(sample_in);
	assign old_sq_full = (2*SAMPLE_W)'(old_sample) * (2*SAMPLE_W)'(old_sample);
	assign mean        = energy_q[ENERGY_W-1:WIN_LOG2];
	assign mean_gt     = mean > MEAN_W'(thr_q);
	assign mean_lt     = mean < MEAN_W'(thr_q);
	assign thr_wr      = THR_W'(cfg_data[14:0]) * THR_W'(cfg_data[14:0]);

	// Floor gain saturates at unity; the ramp spans the rest.
	assign fl   = (floor_gain_q > UNITY) ? UNITY : floor_gain_q;
	assign span = UNITY - fl;

	assign ramp_len_d = (phase_q == PH_OPENING) ? attack_q : release_q;
	assign ramp_full  = (cnt_q >= ramp_len_d);

	// Ramp product; its upper part is already below the length, so 15 quotient bits remain.
	assign prod_d = (CNT_W+GAIN_W)'(ramp_cnt_q) * (CNT_W+GAIN_W)'(span);

	// One restoring division step.
	assign trial    = {rem_q, dvd_q[QUO_W-1]};
	assign trial_ge = (trial >= {1'b0, ramp_len_q});
	assign quo_next = {dvd_q[QUO_W-2:0], trial_ge};

	// Gain product, then truncation toward zero.
	assign gp_d   = (2*SAMPLE_W+1)'(sample_s1) * (2*SAMPLE_W+1)'($signed({1'b0, gain_q}));
	assign gp_adj = gp_q + (gp_q[2*SAMPLE_W] ? (2*SAMPLE_W+1)'(32767) : '0);

	// Sequencer and gate state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_CLOSED;
			cnt_q        <= '0;
			energy_q     <= '0;
			ptr_q        <= '0;
			warm_q       <= '0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
			thr_q        <= THR_W'(6400);
			floor_gain_q <= '0;
			attack_q     <= CNT_W'(441);
			release_q    <= CNT_W'(441);
			hold_q       <= CNT_W'(11025);
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_THRESHOLD: thr_q        <= thr_wr;
					CFG_FLOOR:     floor_gain_q <= cfg_data[GAIN_W-1:0];
					CFG_ATTACK:    attack_q     <= cfg_data;
					CFG_RELEASE:   release_q    <= cfg_data;
					CFG_HOLD:      hold_q       <= cfg_data;
					default: begin
					end
				endcase
			end

			// The finishing state reloads the output register itself.
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ENG;
					end
				end
				ST_ENG: begin
					ptr_q <= ptr_q + 1'b1;
					if (!warm_done) begin
						energy_q <= energy_q + ENERGY_W'(sq_s1);
						warm_q   <= warm_q + 1'b1;
						state_q  <= ST_GAIN;
					end else begin
						energy_q <= energy_q - ENERGY_W'(old_sq_full[SQ_W-1:0])
							+ ENERGY_W'(sq_s1);
						state_q  <= ST_DEC;
					end
				end
				ST_DEC: begin
					state_q <= ST_GAIN;
					case (phase_q)
						PH_CLOSED: begin
							if (mean_gt) begin
								phase_q <= PH_OPENING;
								cnt_q   <= attack_q;
							end
						end
						PH_OPEN: begin
							if (mean_lt) begin
								if (cnt_q != '0) begin
									cnt_q <= cnt_q - 1'b1;
								end else begin
									phase_q <= PH_CLOSING;
									cnt_q   <= release_q;
								end
							end
						end
						default: begin
							// Ramping up or down: step the ramp, or finish it.
							if (cnt_q != '0) begin
								cnt_q <= cnt_q - 1'b1;
								if (!ramp_full) begin
									state_q <= ST_MUL;
								end
							end else if (phase_q == PH_OPENING) begin
								phase_q <= PH_OPEN;
								cnt_q   <= hold_q;
							end else begin
								phase_q <= PH_CLOSED;
							end
						end
					endcase
				end
				ST_MUL: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CW'(QUO_W - 1)) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_in;
			sq_s1     <= sq_full[SQ_W-1:0];
		end

		if (state_q == ST_ENG) begin
			gain_q <= UNITY;
		end

		if (state_q == ST_DEC) begin
			ramp_cnt_q <= cnt_q;
			ramp_len_q <= ramp_len_d;
			ramp_up_q  <= (phase_q == PH_OPENING);
			case (phase_q)
				PH_CLOSED: gain_q <= fl;
				PH_OPENING: gain_q <= (cnt_q != '0 && ramp_full) ? fl : UNITY;
				PH_OPEN: gain_q <= UNITY;
				default: gain_q <= (cnt_q != '0) ? UNITY : fl;
			endcase
		end

		if (state_q == ST_MUL) begin
			rem_q <= prod_d[CNT_W+QUO_W-1:QUO_W];
			dvd_q <= prod_d[QUO_W-1:0];
		end

		if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? CNT_W'(trial - {1'b0, ramp_len_q}) : trial[CNT_W-1:0];
			dvd_q <= quo_next;
			if (div_cnt_q == DIV_CW'(QUO_W - 1)) begin
				gain_q <= ramp_up_q ? (UNITY - GAIN_W'(quo_next)) : (fl + GAIN_W'(quo_next));
			end
		end

		if (state_q == ST_GAIN) begin
			gp_q <= gp_d;
		end

		if (state_q == ST_FIN && out_free) begin
			sample_out_q <= gp_adj[SAMPLE_W+QUO_W-1:QUO_W];
			phase_out_q  <= phase_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign gate_phase = phase_out_q;

	// An accepted sample always starts the energy update next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ENG))
		else $error("accepted sample did not start the energy update");

	// The divider remainder stays below the ramp length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < ramp_len_q))
		else $error("divider remainder out of range");

	// The applied gain never exceeds unity.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GAIN) |-> (gain_q <= UNITY))
		else $error("gain above unity");

	// The warm-up count saturates at the window length.
	assert property (@(posedge clk) disable iff (!arst_n)
		warm_q <= WARM_W'(WINDOW))
		else $error("warm-up count overran the window");

	// A result is only loaded when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && out_stall) |=> $stable(sample_out_q))
		else $error("pending result overwritten");

endmodule

/* rtl/core/ang_ram.sv */
module ang_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
